// ----- design/esac_pkg.sv -----
package esac_pkg;

    // Unit state codes, also used as the code of a deferred RF enable
    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_CUT   = 4'd1,
        ST_COAG  = 4'd2,
        ST_BCUT  = 4'd3,
        ST_BCOAG = 4'd4,
        ST_PCUT  = 4'd5,
        ST_PCOAG = 4'd6,
        ST_REM   = 4'd7,
        ST_ERR   = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        DRV_OFF  = 2'd0,
        DRV_CUT  = 2'd1,
        DRV_COAG = 2'd2,
        DRV_BIP  = 2'd3
    } drive_t;

    typedef enum logic [1:0] {
        TONE_OFF  = 2'd0,
        TONE_CUT  = 2'd1,
        TONE_COAG = 2'd2
    } tone_t;

    typedef enum logic [2:0] {
        RLY_NONE  = 3'd0,
        RLY_CUT   = 3'd1,
        RLY_COAG  = 3'd2,
        RLY_PCUT  = 3'd3,
        RLY_BCUT  = 3'd4,
        RLY_BCOAG = 3'd5,
        RLY_SOFT  = 3'd6
    } relay_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHANNEL_BIPOLAR = 3'd0,
        CFG_CUT_POLY        = 3'd1,
        CFG_COAG_AUTOSTART  = 3'd2,
        CFG_POLY_CUT_TICKS  = 3'd3,
        CFG_POLY_COAG_TICKS = 3'd4,
        CFG_CUT_POWER       = 3'd5,
        CFG_COAG_POWER      = 3'd6
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int POWER_W    = 10;
    localparam int ERR_W      = 3;

    localparam logic [TICK_W-1:0]  POLY_CUT_TICKS_RST  = 16'd4;
    localparam logic [TICK_W-1:0]  POLY_COAG_TICKS_RST = 16'd50;
    localparam logic [POWER_W-1:0] POWER_RST           = 10'd30;

    // Error flag bits
    localparam int ERR_BIT_REM = 0;
    localparam int ERR_BIT_OC  = 1;
    localparam int ERR_BIT_OT  = 2;

    // Controller state as it moves through one control step
    typedef struct packed {
        mode_t              mode;
        mode_t              pend;
        logic [TICK_W-1:0]  cnt;
        drive_t             drive;
        tone_t              tone;
        logic [ERR_W-1:0]   err;
        relay_t             relay;
    } ctl_t;

    // State change: exit actions of the old state, entry actions of the new one
    function automatic ctl_t enter_state(ctl_t s, mode_t ns);
        ctl_t r;
        r = s;
        case (s.mode)
            ST_CUT, ST_PCUT, ST_COAG, ST_PCOAG, ST_BCUT, ST_BCOAG:
            begin
                r.drive = DRV_OFF;
                r.tone  = TONE_OFF;
            end
            default: ;
        endcase
        r.mode = ns;
        r.pend = ST_IDLE;
        case (ns)
            ST_IDLE:
            begin
                r.drive = DRV_OFF;
                r.tone  = TONE_OFF;
                r.err   = r.err & 3'b001;
            end
            ST_CUT:
            begin
                r.relay = RLY_CUT;
                r.pend  = ST_CUT;
            end
            ST_COAG:
            begin
                r.relay = RLY_COAG;
                r.pend  = ST_COAG;
            end
            ST_BCUT:
            begin
                r.relay = RLY_BCUT;
                r.pend  = ST_BCUT;
            end
            ST_BCOAG:
            begin
                r.relay = RLY_BCOAG;
                r.pend  = ST_BCOAG;
            end
            ST_PCUT:
            begin
                r.cnt   = '0;
                r.relay = RLY_PCUT;
                r.pend  = ST_PCUT;
            end
            ST_REM:
            begin
                r.drive = DRV_OFF;
                r.tone  = TONE_OFF;
                r.err[ERR_BIT_REM] = 1'b1;
            end
            ST_ERR:
            begin
                r.drive = DRV_OFF;
                r.tone  = TONE_OFF;
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

// ----- design/electrosurgical_activation_controller_top.sv -----
// A result is registered in the cycle after its input beat is accepted.
// Throughput: one control step per cycle; the input side stalls only while a
// finished result waits for out_ready, with the output register as the stage.
// The step is one pass of priority logic and a 16-bit tick compare.
// Reset: state idle, generator and tone off, error flags clear, registers at
// their defaults (ticks 4 and 50, power 30 W); no result pending.
module electrosurgical_activation_controller_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [esac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [esac_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               poly_tick,
    input  logic                               relay_settled,
    input  logic                               fault_rem,
    input  logic                               fault_overcurrent,
    input  logic                               fault_overtemp,
    input  logic                               cut_pedal,
    input  logic                               coag_pedal,
    input  logic                               auto_contact,
    // output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [3:0]                         unit_state,
    output logic [1:0]                         rf_drive,
    output logic [1:0]                         tone,
    output logic [2:0]                         relay_request,
    output logic [esac_pkg::ERR_W-1:0]         error_flags,
    output logic [esac_pkg::POWER_W-1:0]       power_target_w
);
    import esac_pkg::*;

    // configuration registers
    logic                 channel_bipolar_reg;
    logic                 cut_polypectomy_reg;
    logic                 coag_autostart_reg;
    logic [TICK_W-1:0]    poly_cut_ticks_reg;
    logic [TICK_W-1:0]    poly_coag_ticks_reg;
    logic [POWER_W-1:0]   cut_power_w_reg;
    logic [POWER_W-1:0]   coag_power_w_reg;

    // controller state
    mode_t                mode_reg;
    mode_t                pend_reg;
    logic [TICK_W-1:0]    cnt_reg;
    drive_t               drive_reg;
    tone_t                tone_reg;
    logic [ERR_W-1:0]     error_reg;

    // result register
    logic                 out_valid_reg;
    mode_t                unit_state_reg;
    drive_t               rf_drive_reg;
    tone_t                tone_out_reg;
    relay_t               relay_request_reg;
    logic [ERR_W-1:0]     error_flags_reg;
    logic [POWER_W-1:0]   power_reg;

    ctl_t                 ctl_next;
    logic [POWER_W-1:0]   power_next;
    logic                 in_fire;
    logic                 cfg_fire;
    logic                 cfg_take;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    // writes only land while the unit is idle
    assign cfg_take  = cfg_fire && (mode_reg == ST_IDLE);

    // one control step
    always_comb
    begin
        ctl_t   s;
        logic   go_coag;
        logic   go_cut;
        logic   skip;
        logic [TICK_W-1:0] cnt_inc;

        s.mode  = mode_reg;
        s.pend  = pend_reg;
        s.cnt   = cnt_reg;
        s.drive = drive_reg;
        s.tone  = tone_reg;
        s.err   = error_reg;
        s.relay = RLY_NONE;
        go_coag = 1'b0;
        go_cut  = 1'b0;
        skip    = 1'b0;
        cnt_inc = cnt_reg + 16'd1;

        // polypectomy tick count
        if (poly_tick && (s.mode == ST_PCUT || s.mode == ST_PCOAG))
        begin
            s.cnt = cnt_inc;
            if (s.mode == ST_PCUT)
            begin
                if (cnt_inc >= poly_cut_ticks_reg)
                begin
                    s.cnt   = '0;
                    go_coag = 1'b1;
                end
            end
            else if (cnt_inc >= poly_coag_ticks_reg)
            begin
                s.cnt  = '0;
                go_cut = 1'b1;
            end
        end

        // deferred RF enable once the relays settle
        if (s.pend != ST_IDLE && relay_settled)
        begin
            case (s.pend)
                ST_CUT, ST_PCUT:
                begin
                    s.drive = DRV_CUT;
                    s.tone  = TONE_CUT;
                end
                ST_COAG, ST_PCOAG:
                begin
                    s.drive = DRV_COAG;
                    s.tone  = TONE_COAG;
                end
                ST_BCUT:
                begin
                    s.drive = DRV_BIP;
                    s.tone  = TONE_CUT;
                end
                ST_BCOAG:
                begin
                    s.drive = DRV_BIP;
                    s.tone  = TONE_COAG;
                end
                default: ;
            endcase
            s.pend = ST_IDLE;
        end

        // polypectomy swap; tone holds until the enable
        if (go_coag && s.mode == ST_PCUT)
        begin
            s.drive = DRV_OFF;
            s.relay = RLY_SOFT;
            s.pend  = ST_PCOAG;
            s.mode  = ST_PCOAG;
        end
        if (go_cut && s.mode == ST_PCOAG)
        begin
            s.drive = DRV_OFF;
            s.relay = RLY_PCUT;
            s.pend  = ST_PCUT;
            s.mode  = ST_PCUT;
        end

        // faults in priority order
        if (fault_rem)
        begin
            if (s.mode != ST_REM && s.mode != ST_ERR)
                s = enter_state(s, ST_REM);
            skip = 1'b1;
        end
        if (!skip && s.mode == ST_REM)
            s = enter_state(s, ST_IDLE);
        if (!skip && fault_overcurrent)
        begin
            s.err[ERR_BIT_OC] = 1'b1;
            s = enter_state(s, ST_ERR);
            skip = 1'b1;
        end
        if (!skip && fault_overtemp)
        begin
            s.err[ERR_BIT_OT] = 1'b1;
            s = enter_state(s, ST_ERR);
            skip = 1'b1;
        end
        if (s.mode == ST_ERR)
            skip = 1'b1;

        // activation from pedal levels
        if (!skip)
        begin
            case (s.mode)
                ST_IDLE:
                begin
                    if (channel_bipolar_reg)
                    begin
                        if (auto_contact && coag_autostart_reg)
                            s = enter_state(s, ST_BCOAG);
                        else if (cut_pedal)
                            s = enter_state(s, ST_BCUT);
                        else if (coag_pedal)
                            s = enter_state(s, ST_BCOAG);
                    end
                    else
                    begin
                        if (cut_pedal)
                            s = enter_state(s, cut_polypectomy_reg ? ST_PCUT : ST_CUT);
                        else if (coag_pedal)
                            s = enter_state(s, ST_COAG);
                    end
                end
                ST_CUT, ST_BCUT, ST_PCUT, ST_PCOAG:
                begin
                    if (!cut_pedal)
                        s = enter_state(s, ST_IDLE);
                end
                ST_COAG:
                begin
                    if (!coag_pedal)
                        s = enter_state(s, ST_IDLE);
                end
                ST_BCOAG:
                begin
                    if (coag_autostart_reg ? !auto_contact : !coag_pedal)
                        s = enter_state(s, ST_IDLE);
                end
                default: ;
            endcase
        end

        ctl_next = s;
    end

    // power target of the resulting state
    always_comb
    begin
        case (ctl_next.mode)
            ST_CUT, ST_BCUT, ST_PCUT:    power_next = cut_power_w_reg;
            ST_COAG, ST_BCOAG, ST_PCOAG: power_next = coag_power_w_reg;
            default:                     power_next = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_bipolar_reg <= 1'b0;
            cut_polypectomy_reg <= 1'b0;
            coag_autostart_reg  <= 1'b0;
            poly_cut_ticks_reg  <= POLY_CUT_TICKS_RST;
            poly_coag_ticks_reg <= POLY_COAG_TICKS_RST;
            cut_power_w_reg     <= POWER_RST;
            coag_power_w_reg    <= POWER_RST;
        end
        else if (cfg_take)
        begin
            case (cfg_index)
                CFG_CHANNEL_BIPOLAR: channel_bipolar_reg <= cfg_data[0];
                CFG_CUT_POLY:        cut_polypectomy_reg <= cfg_data[0];
                CFG_COAG_AUTOSTART:  coag_autostart_reg  <= cfg_data[0];
                CFG_POLY_CUT_TICKS:  poly_cut_ticks_reg  <= cfg_data[TICK_W-1:0];
                CFG_POLY_COAG_TICKS: poly_coag_ticks_reg <= cfg_data[TICK_W-1:0];
                CFG_CUT_POWER:       cut_power_w_reg     <= cfg_data[POWER_W-1:0];
                CFG_COAG_POWER:      coag_power_w_reg    <= cfg_data[POWER_W-1:0];
                default: ;
            endcase
        end
    end

    // controller state update on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ST_IDLE;
            pend_reg  <= ST_IDLE;
            cnt_reg   <= '0;
            drive_reg <= DRV_OFF;
            tone_reg  <= TONE_OFF;
            error_reg <= '0;
        end
        else if (in_fire)
        begin
            mode_reg  <= ctl_next.mode;
            pend_reg  <= ctl_next.pend;
            cnt_reg   <= ctl_next.cnt;
            drive_reg <= ctl_next.drive;
            tone_reg  <= ctl_next.tone;
            error_reg <= ctl_next.err;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            unit_state_reg    <= ctl_next.mode;
            rf_drive_reg      <= ctl_next.drive;
            tone_out_reg      <= ctl_next.tone;
            relay_request_reg <= ctl_next.relay;
            error_flags_reg   <= ctl_next.err;
            power_reg         <= power_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign unit_state     = unit_state_reg;
    assign rf_drive       = rf_drive_reg;
    assign tone           = tone_out_reg;
    assign relay_request  = relay_request_reg;
    assign error_flags    = error_flags_reg;
    assign power_target_w = power_reg;

    // error state latches until reset
    a_err_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == ST_ERR) |=> (mode_reg == ST_ERR))
        else $error("error state left without reset");

    // REM flag is sticky
    a_rem_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg[ERR_BIT_REM] |=> error_reg[ERR_BIT_REM])
        else $error("REM flag cleared without reset");

    // no RF drive outside an activation state
    a_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (unit_state_reg == ST_IDLE || unit_state_reg == ST_REM ||
         unit_state_reg == ST_ERR)) |-> (rf_drive_reg == DRV_OFF))
        else $error("RF drive on while inactive");

    // settings hold while the unit is active
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != ST_IDLE) |=> ($stable(cut_power_w_reg) && $stable(poly_cut_ticks_reg)))
        else $error("configuration changed while active");

endmodule
